// ===== rtl/core/hssq_pkg.sv =====
`timescale 1ns / 1ps
// Package with the types, constants and pattern table of the half-step rate sequencer.
package hssq_pkg;

    localparam int WORD_BITS = 16;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(1);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-1:0] count_t;

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    typedef enum logic
    {
        CFG_STEP_PERIOD = 1'b0,
        CFG_CORRECTION_PERIOD = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        opcode_t opcode;
        word_t correction_amount;
    } cmd_t;

    typedef struct packed
    {
        logic [3:0] coil_pattern;
        word_t correction_left;
    } res_t;

    typedef struct packed
    {
        word_t step_period;
        word_t correction_period;
    } cfg_t;

    typedef struct packed
    {
        count_t main_tick_count;
        count_t corr_tick_count;
        word_t pending_steps;
        word_t correction_remaining;
        logic [2:0] phase_index;
        logic [3:0] coil_hold;
    } state_t;

    function automatic logic [3:0] half_step_pattern(input logic [2:0] idx);
        logic [3:0] pattern;
        unique case (idx)
            3'd0: pattern = 4'h1;
            3'd1: pattern = 4'h3;
            3'd2: pattern = 4'h2;
            3'd3: pattern = 4'h6;
            3'd4: pattern = 4'h4;
            3'd5: pattern = 4'hC;
            3'd6: pattern = 4'h8;
            3'd7: pattern = 4'h9;
            default: pattern = 4'h0;
        endcase
        return pattern;
    endfunction

    // Adds one step up or down, holding at the signed limits.
    function automatic word_t sat_step(input word_t value, input logic down);
        word_t result;
        if (down)
        begin
            result = (value == WORD_MIN) ? value : value - WORD_ONE;
        end
        else
        begin
            result = (value == WORD_MAX) ? value : value + WORD_ONE;
        end
        return result;
    endfunction

    // Magnitude of a signed period; the most negative value gives 2^(WORD_BITS-1).
    function automatic count_t period_mag(input word_t value);
        count_t result;
        if (value[WORD_BITS-1])
        begin
            result = ~count_t'(value) + count_t'(1);
        end
        else
        begin
            result = count_t'(value);
        end
        return result;
    endfunction

endpackage

// ===== rtl/core/hssq_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers for the step period and the correction period.
module hssq_cfg
    import hssq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  word_t      cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STEP_PERIOD: cfg_next.step_period = cfg_data;
                CFG_CORRECTION_PERIOD: cfg_next.correction_period = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/hssq_step.sv =====
`timescale 1ns / 1ps
// Next-state logic for one request: correction load, or dividers, pending step count, phase and coil pattern.
module hssq_step
    import hssq_pkg::*;
(
    input  state_t st,
    input  cfg_t   cfg,
    input  cmd_t   cmd,
    output state_t st_next,
    output res_t   res
);

    logic main_on;
    logic corr_on;
    logic corr_down;
    count_t main_count;
    count_t corr_count;
    count_t main_mag;
    count_t corr_mag;
    word_t pending;

    assign main_mag = period_mag(cfg.step_period);
    assign corr_mag = period_mag(cfg.correction_period);
    assign main_count = st.main_tick_count + count_t'(1);
    assign corr_count = st.corr_tick_count + count_t'(1);
    assign main_on = (cfg.step_period != '0);
    assign corr_on = (cfg.correction_period != '0) && (st.correction_remaining != '0);
    assign corr_down = st.correction_remaining[WORD_BITS-1];

    always_comb
    begin
        st_next = st;
        pending = st.pending_steps;
        if (cmd.opcode == OP_LOAD)
        begin
            st_next.correction_remaining = cmd.correction_amount;
        end
        else if (main_on || corr_on)
        begin
            if (main_on)
            begin
                if (main_mag <= main_count)
                begin
                    pending = sat_step(pending, cfg.step_period[WORD_BITS-1]);
                    st_next.main_tick_count = '0;
                end
                else
                begin
                    st_next.main_tick_count = main_count;
                end
            end
            if (corr_on)
            begin
                if (corr_mag <= corr_count)
                begin
                    pending = sat_step(pending, corr_down);
                    st_next.correction_remaining = corr_down
                        ? st.correction_remaining + WORD_ONE
                        : st.correction_remaining - WORD_ONE;
                    st_next.corr_tick_count = '0;
                end
                else
                begin
                    st_next.corr_tick_count = corr_count;
                end
            end
            if (pending[WORD_BITS-1])
            begin
                st_next.phase_index = st.phase_index - 3'd1;
                pending = pending + WORD_ONE;
            end
            else if (pending != '0)
            begin
                st_next.phase_index = st.phase_index + 3'd1;
                pending = pending - WORD_ONE;
            end
            st_next.pending_steps = pending;
            st_next.coil_hold = half_step_pattern(st_next.phase_index);
        end
        else
        begin
            st_next.coil_hold = 4'h0;
        end
    end

    assign res.coil_pattern = st_next.coil_hold;
    assign res.correction_left = st_next.correction_remaining;

endmodule

// ===== rtl/core/stepper_half_step_rate_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the half-step rate sequencer: state registers and result register.
// The sequencer takes one request per clock cycle, as the handshake below allows, and returns
// its result in the next cycle from a result register. A request is accepted whenever the
// result register is empty or its result is being taken in the same cycle, so with a ready
// consumer the throughput is one request per cycle. All work for a request (divider counters,
// saturating pending count, phase update and half-step table lookup) is combinational.
module stepper_half_step_rate_sequencer
    import hssq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  word_t      cfg_data,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res
);

    cfg_t cfg;
    state_t state_reg;
    state_t state_next;
    res_t res_next;
    res_t res_reg;
    logic res_valid_reg;
    logic cmd_fire;

    hssq_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hssq_step u_step
    (
        .st      (state_reg),
        .cfg     (cfg),
        .cmd     (cmd),
        .st_next (state_next),
        .res     (res_next)
    );

    assign cmd_ready = !res_valid_reg || res_ready;
    assign cmd_fire = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                state_reg <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule
